// File: hdl/cse_pkg.sv
package cse_pkg;

	localparam int CFG_W   = 10;
	localparam int INDEX_W = 3;
	localparam int COUNT_W = 11;
	localparam int MAIN_N  = 4;
	localparam int BRK_N   = 4;

	typedef enum logic [INDEX_W-1:0] {
		CFG_LINE_LIMIT  = 3'd0,
		CFG_BREAK_NL    = 3'd1,
		CFG_REPL_SQUOTE = 3'd2,
		CFG_ALLOW_BREAK = 3'd3,
		CFG_NUL_TERM    = 3'd4
	} cfg_index_t;

	typedef struct packed {
		logic [CFG_W-1:0] line_limit;
		logic             break_nl;
		logic             repl_squote;
		logic             allow_break;
		logic             nul_term;
	} cfg_t;

	// One queued run: up to four escape characters, optionally followed by a line break.
	typedef struct packed {
		logic [MAIN_N-1:0][7:0] main;
		logic [2:0]             main_len;
		logic                   brk;
	} run_t;

	localparam logic [7:0] CH_NUL    = 8'h00;
	localparam logic [7:0] CH_TAB    = 8'h09;
	localparam logic [7:0] CH_LF     = 8'h0A;
	localparam logic [7:0] CH_CR     = 8'h0D;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_ZERO   = 8'h30;
	localparam logic [7:0] CH_NINE   = 8'h39;
	localparam logic [7:0] CH_QMARK  = 8'h3F;
	localparam logic [7:0] CH_UA     = 8'h41;
	localparam logic [7:0] CH_UF     = 8'h46;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_LA     = 8'h61;
	localparam logic [7:0] CH_LF_HEX = 8'h66;
	localparam logic [7:0] CH_N      = 8'h6E;
	localparam logic [7:0] CH_R      = 8'h72;
	localparam logic [7:0] CH_T      = 8'h74;
	localparam logic [7:0] CH_X      = 8'h78;
	localparam logic [7:0] PRINT_LO  = 8'd32;
	localparam logic [7:0] PRINT_HI  = 8'd127;

	localparam logic [BRK_N-1:0][7:0] BRK_SEQ = {CH_DQUOTE, CH_LF, CH_CR, CH_DQUOTE};

	function automatic logic [7:0] hex_char(input logic [3:0] v);
		if (v < 4'd10)
			return CH_ZERO + {4'd0, v};
		else
			return CH_LA + {4'd0, v} - 8'd10;
	endfunction

endpackage

// File: hdl/cse_if.sv
interface cse_byte_if;
	logic       valid;
	logic       ready;
	logic [7:0] in_byte;
	logic       last_of_string;

	modport source(output valid, output in_byte, output last_of_string, input ready);
	modport sink(input valid, input in_byte, input last_of_string, output ready);
endinterface

interface cse_char_if;
	logic       valid;
	logic       ready;
	logic [7:0] out_char;
	logic       end_of_run;

	modport source(output valid, output out_char, output end_of_run, input ready);
	modport sink(input valid, input out_char, input end_of_run, output ready);
endinterface

// File: hdl/c_string_escape_encoder_top.sv
// Channel   Modport  Payload                     Beat
// byte_ch   sink     in_byte[7:0], last_of_string  valid & ready
// char_ch   source   out_char[7:0], end_of_run     valid & ready
// cfg       write    cfg_index[2:0], cfg_data[9:0] cfg_we
//
// One source byte is taken per cycle while the run queue has room; a byte expands
// to 1..8 output characters, delivered one per cycle by the back end while char_ch
// is ready. A zero byte in NUL mode yields nothing. Reset clears the queue, the
// escape state and the output register, and loads the register defaults. A stalled
// char_ch holds its beat; once the queue fills, byte_ch.ready drops.
module c_string_escape_encoder_top #(
	parameter int DEPTH = 4
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [cse_pkg::INDEX_W-1:0]  cfg_index,
	input  logic [cse_pkg::CFG_W-1:0]    cfg_data,
	cse_byte_if.sink                     byte_ch,
	cse_char_if.source                   char_ch
);

	cse_pkg::cfg_t cfg_q;
	cse_pkg::run_t push_run, head;
	logic          push, push_ready, pop, head_valid;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.line_limit <= '0;
			cfg_q.break_nl <= 1'b0;
			cfg_q.repl_squote <= 1'b1;
			cfg_q.allow_break <= 1'b1;
			cfg_q.nul_term <= 1'b1;
		end else if (cfg_we) begin
			case (cfg_index)
				cse_pkg::CFG_LINE_LIMIT:  cfg_q.line_limit <= cfg_data;
				cse_pkg::CFG_BREAK_NL:    cfg_q.break_nl <= cfg_data[0];
				cse_pkg::CFG_REPL_SQUOTE: cfg_q.repl_squote <= cfg_data[0];
				cse_pkg::CFG_ALLOW_BREAK: cfg_q.allow_break <= cfg_data[0];
				cse_pkg::CFG_NUL_TERM:    cfg_q.nul_term <= cfg_data[0];
				default: ;
			endcase
		end
	end

	cse_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg     (cfg_q),
		.byte_ch (byte_ch),
		.q_ready (push_ready),
		.push    (push),
		.run     (push_run)
	);

	cse_queue #(
		.DEPTH(DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_run   (push_run),
		.push_ready (push_ready),
		.pop        (pop),
		.head       (head),
		.head_valid (head_valid)
	);

	cse_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head       (head),
		.head_valid (head_valid),
		.pop        (pop),
		.char_ch    (char_ch)
	);

endmodule

// File: hdl/cse_front.sv
module cse_front (
	input  logic          clk,
	input  logic          arst_n,
	input  cse_pkg::cfg_t cfg,
	cse_byte_if.sink      byte_ch,
	input  logic          q_ready,
	output logic          push,
	output cse_pkg::run_t run
);

	logic                        hex_q, q_seen_q;
	logic [cse_pkg::COUNT_W-1:0] count_q;

	logic                        accept, drop, nl, brk, last;
	logic                        hex_n, q_n, hex_d, q_d;
	logic                        printable, is_hex;
	logic [7:0]                  c;
	logic [2:0]                  add;
	logic [cse_pkg::COUNT_W:0]   sum;
	logic [cse_pkg::COUNT_W-1:0] cnt_after, count_d;

	assign byte_ch.ready = q_ready;
	assign accept = byte_ch.valid && q_ready;
	assign c = byte_ch.in_byte;
	assign last = byte_ch.last_of_string;

	assign printable = (c >= cse_pkg::PRINT_LO) && (c < cse_pkg::PRINT_HI);
	assign is_hex = (c >= cse_pkg::CH_ZERO && c <= cse_pkg::CH_NINE)
		|| (c >= cse_pkg::CH_LA && c <= cse_pkg::CH_LF_HEX)
		|| (c >= cse_pkg::CH_UA && c <= cse_pkg::CH_UF);

	always_comb begin
		run.main = '0;
		run.main_len = 3'd0;
		add = 3'd0;
		hex_n = hex_q;
		q_n = q_seen_q;
		nl = 1'b0;
		drop = 1'b0;
		if (c == cse_pkg::CH_NUL && cfg.nul_term) begin
			drop = 1'b1;
		end else if (c == cse_pkg::CH_TAB || c == cse_pkg::CH_CR || c == cse_pkg::CH_LF
			|| c == cse_pkg::CH_BSLASH || c == cse_pkg::CH_DQUOTE
			|| (c == cse_pkg::CH_SQUOTE && cfg.repl_squote)) begin
			run.main[0] = cse_pkg::CH_BSLASH;
			if (c == cse_pkg::CH_TAB)
				run.main[1] = cse_pkg::CH_T;
			else if (c == cse_pkg::CH_CR)
				run.main[1] = cse_pkg::CH_R;
			else if (c == cse_pkg::CH_LF)
				run.main[1] = cse_pkg::CH_N;
			else
				run.main[1] = c;
			run.main_len = 3'd2;
			add = 3'd2;
			hex_n = 1'b0;
			q_n = 1'b0;
			nl = (c == cse_pkg::CH_LF) && cfg.break_nl;
		end else if (c == cse_pkg::CH_QMARK) begin
			if (q_seen_q) begin
				run.main[0] = cse_pkg::CH_BSLASH;
				run.main[1] = cse_pkg::CH_QMARK;
				run.main_len = 3'd2;
				add = 3'd2;
				q_n = 1'b0;
			end else begin
				run.main[0] = cse_pkg::CH_QMARK;
				run.main_len = 3'd1;
				add = 3'd1;
				q_n = 1'b1;
			end
			hex_n = 1'b0;
		end else if (c == cse_pkg::CH_NUL) begin
			run.main[0] = cse_pkg::CH_BSLASH;
			run.main[1] = cse_pkg::CH_ZERO;
			run.main_len = 3'd2;
			add = 3'd2;
			hex_n = 1'b1;
			q_n = 1'b0;
		end else if (printable && !(hex_q && is_hex)) begin
			run.main[0] = c;
			run.main_len = 3'd1;
			add = 3'd1;
			hex_n = 1'b0;
			q_n = 1'b0;
		end else if (cfg.allow_break && hex_q && printable) begin
			run.main[0] = cse_pkg::CH_DQUOTE;
			run.main[1] = cse_pkg::CH_DQUOTE;
			run.main[2] = c;
			run.main_len = 3'd3;
			add = 3'd3;
			hex_n = 1'b0;
			q_n = 1'b0;
		end else begin
			run.main[0] = cse_pkg::CH_BSLASH;
			run.main[1] = cse_pkg::CH_X;
			run.main[2] = cse_pkg::hex_char(c[7:4]);
			run.main[3] = cse_pkg::hex_char(c[3:0]);
			run.main_len = 3'd4;
			add = 3'd4;
			hex_n = 1'b1;
			q_n = 1'b0;
		end
	end

	// The counter saturates rather than wrapping.
	assign sum = {1'b0, count_q} + {{(cse_pkg::COUNT_W-2){1'b0}}, add};
	assign cnt_after = sum[cse_pkg::COUNT_W] ? {cse_pkg::COUNT_W{1'b1}}
		: sum[cse_pkg::COUNT_W-1:0];

	assign brk = (nl || (cfg.line_limit != '0 && cnt_after >= {1'b0, cfg.line_limit}))
		&& (cfg.nul_term || !last);
	assign run.brk = brk;

	always_comb begin
		count_d = brk ? '0 : cnt_after;
		hex_d = brk ? 1'b0 : hex_n;
		q_d = q_n;
		if (drop || (!cfg.nul_term && last)) begin
			count_d = '0;
			hex_d = 1'b0;
			q_d = 1'b0;
		end
	end

	assign push = accept && !drop;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hex_q <= 1'b0;
			q_seen_q <= 1'b0;
			count_q <= '0;
		end else if (accept) begin
			hex_q <= hex_d;
			q_seen_q <= q_d;
			count_q <= count_d;
		end
	end

endmodule

// File: hdl/cse_queue.sv
module cse_queue #(
	parameter int DEPTH = 4
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  cse_pkg::run_t push_run,
	output logic          push_ready,
	input  logic          pop,
	output cse_pkg::run_t head,
	output logic          head_valid
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);
	localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
	localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

	cse_pkg::run_t    mem [DEPTH];
	logic [PTR_W-1:0] wr_q, rd_q;
	logic [CNT_W-1:0] count_q;

	assign push_ready = (count_q != FULL_CNT);
	assign head_valid = (count_q != '0);
	assign head = mem[rd_q];

	always_ff @(posedge clk) begin
		if (push)
			mem[wr_q] <= push_run;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= '0;
			rd_q <= '0;
			count_q <= '0;
		end else begin
			if (push)
				wr_q <= (wr_q == LAST_PTR) ? '0 : wr_q + 1'b1;
			if (pop)
				rd_q <= (rd_q == LAST_PTR) ? '0 : rd_q + 1'b1;
			if (push && !pop)
				count_q <= count_q + 1'b1;
			else if (pop && !push)
				count_q <= count_q - 1'b1;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= FULL_CNT) else $error("queue count above depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("pop from empty queue");
	a_push_has_room: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> push_ready) else $error("push into full queue");

endmodule

// File: hdl/cse_back.sv
module cse_back (
	input  logic          clk,
	input  logic          arst_n,
	input  cse_pkg::run_t head,
	input  logic          head_valid,
	output logic          pop,
	cse_char_if.source    char_ch
);

	logic [2:0] idx_q;
	logic       valid_q, end_q;
	logic [7:0] char_q;

	logic       adv, last_char;
	logic [3:0] total;
	logic [2:0] brk_idx;
	logic [7:0] next_char;

	assign total = {1'b0, head.main_len} + (head.brk ? 4'd4 : 4'd0);
	assign last_char = ({1'b0, idx_q} == total - 4'd1);
	assign brk_idx = idx_q - head.main_len;
	assign next_char = (idx_q < head.main_len) ? head.main[idx_q[1:0]]
		: cse_pkg::BRK_SEQ[brk_idx[1:0]];

	// The output register refills whenever it is empty or its beat is taken.
	assign adv = !valid_q || char_ch.ready;
	assign pop = adv && head_valid && last_char;

	assign char_ch.valid = valid_q;
	assign char_ch.out_char = char_q;
	assign char_ch.end_of_run = end_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			idx_q <= '0;
		end else if (adv) begin
			valid_q <= head_valid;
			if (head_valid)
				idx_q <= last_char ? '0 : idx_q + 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (adv && head_valid) begin
			char_q <= next_char;
			end_q <= last_char;
		end
	end

	a_idx_in_run: assert property (@(posedge clk) disable iff (!arst_n)
		head_valid |-> {1'b0, idx_q} < total) else $error("character index past run");
	a_idx_restart: assert property (@(posedge clk) disable iff (!arst_n)
		pop |=> idx_q == '0) else $error("index not restarted after run");
	a_beat_held: assert property (@(posedge clk) disable iff (!arst_n)
		valid_q && !char_ch.ready |=> valid_q && $stable(char_q) && $stable(end_q))
		else $error("stalled beat changed");

endmodule

// File: sim/escape_checker.sv
`timescale 1ns / 100ps

module escape_checker (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        cfg_we,
	input  logic [cse_pkg::INDEX_W-1:0] cfg_index,
	input  logic [cse_pkg::CFG_W-1:0]   cfg_data,
	input  logic                        byte_valid,
	input  logic                        byte_ready,
	input  logic [7:0]                  in_byte,
	input  logic                        last_of_string,
	input  logic                        char_valid,
	input  logic                        char_ready,
	input  logic [7:0]                  out_char,
	input  logic                        end_of_run,
	output int                          mismatches,
	output int                          pending_chars
);

	typedef struct packed {
		logic [7:0] ch;
		logic       last;
	} char_beat_t;

	localparam int COUNT_SAT = 2047;

	char_beat_t       expected_chars[$];
	char_beat_t       oldest;
	logic [7:0]       run_buf[8];
	int               run_len;
	string            hex_digits = "0123456789abcdef";

	logic [cse_pkg::CFG_W-1:0] line_limit;
	logic             break_nl;
	logic             repl_squote;
	logic             allow_break;
	logic             nul_term;

	logic             hex_pending;
	logic             question_seen;
	int               line_count;

	task automatic report_mismatch(input string what);
		$display("ERROR t=%0t: %s", $time, what);
		mismatches++;
	endtask

	function automatic void add_char(input logic [7:0] ch);
		if (run_len < 8) begin
			run_buf[run_len] = ch;
			run_len++;
		end
	endfunction

	function automatic void clear_escape_state();
		hex_pending   = 1'b0;
		question_seen = 1'b0;
		line_count    = 0;
	endfunction

	// Expands one source byte into the characters the encoder must emit for it.
	function automatic void encode_byte(input logic [7:0] c, input logic last_in);
		logic printable;
		logic hex_digit;
		logic nl_break;
		int   grow;
		printable = (c >= cse_pkg::PRINT_LO) && (c < cse_pkg::PRINT_HI);
		hex_digit = (c >= cse_pkg::CH_ZERO && c <= cse_pkg::CH_NINE) ||
			(c >= cse_pkg::CH_UA && c <= cse_pkg::CH_UF) ||
			(c >= cse_pkg::CH_LA && c <= cse_pkg::CH_LF_HEX);
		nl_break  = 1'b0;
		grow      = 2;
		run_len   = 0;

		if (c == cse_pkg::CH_NUL && nul_term) begin
			clear_escape_state();
			return;
		end

		if (c == cse_pkg::CH_TAB || c == cse_pkg::CH_CR || c == cse_pkg::CH_LF ||
			c == cse_pkg::CH_BSLASH || c == cse_pkg::CH_DQUOTE ||
			(c == cse_pkg::CH_SQUOTE && repl_squote)) begin
			add_char(cse_pkg::CH_BSLASH);
			case (c)
				cse_pkg::CH_TAB: add_char(cse_pkg::CH_T);
				cse_pkg::CH_CR:  add_char(cse_pkg::CH_R);
				cse_pkg::CH_LF:  add_char(cse_pkg::CH_N);
				default: add_char(c);
			endcase
			hex_pending   = 1'b0;
			question_seen = 1'b0;
			nl_break      = (c == cse_pkg::CH_LF) && break_nl;
		end else if (c == cse_pkg::CH_QMARK) begin
			// A second question mark in a row is escaped so no trigraph can form.
			if (question_seen) begin
				add_char(cse_pkg::CH_BSLASH);
				add_char(cse_pkg::CH_QMARK);
				question_seen = 1'b0;
			end else begin
				add_char(cse_pkg::CH_QMARK);
				grow          = 1;
				question_seen = 1'b1;
			end
			hex_pending = 1'b0;
		end else if (c == cse_pkg::CH_NUL) begin
			add_char(cse_pkg::CH_BSLASH);
			add_char(cse_pkg::CH_ZERO);
			hex_pending   = 1'b1;
			question_seen = 1'b0;
		end else if (printable && !(hex_pending && hex_digit)) begin
			add_char(c);
			grow          = 1;
			hex_pending   = 1'b0;
			question_seen = 1'b0;
		end else if (printable && allow_break) begin
			add_char(cse_pkg::CH_DQUOTE);
			add_char(cse_pkg::CH_DQUOTE);
			add_char(c);
			grow          = 3;
			hex_pending   = 1'b0;
			question_seen = 1'b0;
		end else begin
			add_char(cse_pkg::CH_BSLASH);
			add_char(cse_pkg::CH_X);
			add_char(8'(hex_digits[c[7:4]]));
			add_char(8'(hex_digits[c[3:0]]));
			grow          = 4;
			hex_pending   = 1'b1;
			question_seen = 1'b0;
		end

		line_count = (line_count + grow > COUNT_SAT) ? COUNT_SAT : line_count + grow;

		if ((nl_break || (line_limit != 0 && line_count >= line_limit)) &&
			(nul_term || !last_in)) begin
			add_char(cse_pkg::CH_DQUOTE);
			add_char(cse_pkg::CH_CR);
			add_char(cse_pkg::CH_LF);
			add_char(cse_pkg::CH_DQUOTE);
			line_count  = 0;
			hex_pending = 1'b0;
		end

		if (!nul_term && last_in) begin
			clear_escape_state();
		end

		for (int i = 0; i < run_len; i++) begin
			expected_chars.push_back(char_beat_t'{run_buf[i], i == run_len - 1});
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			expected_chars.delete();
			line_limit    = '0;
			break_nl      = 1'b0;
			repl_squote   = 1'b1;
			allow_break   = 1'b1;
			nul_term      = 1'b1;
			mismatches    = 0;
			pending_chars = 0;
			clear_escape_state();
		end else begin
			// Outputs are checked before new input is predicted, so a beat can never
			// be matched against an expectation from the byte taken at the same edge.
			if (char_valid && char_ready) begin
				if (expected_chars.size() == 0) begin
					report_mismatch($sformatf("unexpected char 0x%02h end_of_run %0b",
						out_char, end_of_run));
				end else begin
					oldest = expected_chars.pop_front();
					if (out_char !== oldest.ch) begin
						report_mismatch($sformatf("out_char 0x%02h, expected 0x%02h",
							out_char, oldest.ch));
					end
					if (end_of_run !== oldest.last) begin
						report_mismatch($sformatf("end_of_run %0b, expected %0b for char 0x%02h",
							end_of_run, oldest.last, oldest.ch));
					end
				end
			end

			if (cfg_we) begin
				case (cfg_index)
					cse_pkg::CFG_LINE_LIMIT:  line_limit  = cfg_data;
					cse_pkg::CFG_BREAK_NL:    break_nl    = cfg_data[0];
					cse_pkg::CFG_REPL_SQUOTE: repl_squote = cfg_data[0];
					cse_pkg::CFG_ALLOW_BREAK: allow_break = cfg_data[0];
					cse_pkg::CFG_NUL_TERM:    nul_term    = cfg_data[0];
					default: ;
				endcase
			end

			if (byte_valid && byte_ready) begin
				encode_byte(in_byte, last_of_string);
			end

			pending_chars = expected_chars.size();
		end
	end

endmodule

// File: sim/testbench.sv
`timescale 1ns / 100ps

module testbench;

	localparam int DRAIN_CYCLES    = 40;
	localparam int RANDOM_PHASES   = 6;
	localparam int PHASE_ITEMS     = 34;
	localparam int LONG_LINE_ITEMS = 30;
	localparam int HOLD_OFF        = 150;

	logic                        clk;
	logic                        arst_n;
	logic                        cfg_we;
	logic [cse_pkg::INDEX_W-1:0] cfg_index;
	logic [cse_pkg::CFG_W-1:0]   cfg_data;

	int                 mismatches;
	int                 pending_chars;
	bit                 gaps_on;
	bit                 stalls_on;
	int                 hold_cycles;

	// Directed bytes as {last_of_string, in_byte}.
	logic [8:0] nul_mode_cases[20] = '{
		{1'b0, 8'h41}, {1'b0, cse_pkg::CH_TAB}, {1'b0, cse_pkg::CH_CR},
		{1'b0, cse_pkg::CH_LF}, {1'b0, cse_pkg::CH_BSLASH},
		{1'b0, cse_pkg::CH_DQUOTE}, {1'b0, cse_pkg::CH_QMARK}, {1'b0, cse_pkg::CH_QMARK},
		{1'b0, cse_pkg::CH_QMARK}, {1'b0, cse_pkg::CH_SQUOTE}, {1'b0, 8'h01},
		{1'b0, cse_pkg::CH_LA}, {1'b0, 8'hFF}, {1'b0, 8'h35},
		{1'b0, 8'h7F}, {1'b0, 8'h47}, {1'b0, 8'h20}, {1'b0, 8'h7E}, {1'b0, cse_pkg::CH_NUL},
		{1'b1, 8'h80}
	};
	logic [8:0] counted_cases[7] = '{
		{1'b0, cse_pkg::CH_NUL}, {1'b0, 8'h37}, {1'b0, cse_pkg::CH_SQUOTE},
		{1'b0, cse_pkg::CH_LF}, {1'b0, 8'h42}, {1'b1, cse_pkg::CH_LF}, {1'b1, 8'hF0}
	};
	logic [7:0] special_chars[8] = '{
		cse_pkg::CH_TAB, cse_pkg::CH_CR, cse_pkg::CH_LF, cse_pkg::CH_BSLASH,
		cse_pkg::CH_DQUOTE, cse_pkg::CH_SQUOTE, cse_pkg::CH_NUL, cse_pkg::CH_QMARK
	};

	cse_byte_if byte_ch();
	cse_char_if char_ch();

	c_string_escape_encoder_top u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.byte_ch   (byte_ch),
		.char_ch   (char_ch)
	);

	escape_checker u_checker (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_we         (cfg_we),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.byte_valid     (byte_ch.valid),
		.byte_ready     (byte_ch.ready),
		.in_byte        (byte_ch.in_byte),
		.last_of_string (byte_ch.last_of_string),
		.char_valid     (char_ch.valid),
		.char_ready     (char_ch.ready),
		.out_char       (char_ch.out_char),
		.end_of_run     (char_ch.end_of_run),
		.mismatches     (mismatches),
		.pending_chars  (pending_chars)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	initial begin
		#4_800_000;
		$display("Mismatches found");
		$finish;
	end

	// Character sink: random stall bursts, plus one long hold-off on request.
	initial begin
		char_ch.ready = 1'b0;
		@(posedge arst_n);
		forever begin
			@(negedge clk);
			if (hold_cycles > 0) begin
				char_ch.ready <= 1'b0;
				repeat (hold_cycles) @(negedge clk);
				hold_cycles = 0;
			end else if (stalls_on && $urandom_range(0, 5) == 0) begin
				char_ch.ready <= 1'b0;
				repeat ($urandom_range(0, 7)) @(negedge clk);
			end else begin
				char_ch.ready <= 1'b1;
			end
		end
	end

	task automatic write_reg(input cse_pkg::cfg_index_t idx,
		input logic [cse_pkg::CFG_W-1:0] value);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= value;
		@(negedge clk);
		cfg_we    <= 1'b0;
	endtask

	task automatic program_regs(input logic [cse_pkg::CFG_W-1:0] limit, input logic brk,
		input logic repl, input logic allow, input logic nul);
		write_reg(cse_pkg::CFG_LINE_LIMIT, limit);
		write_reg(cse_pkg::CFG_BREAK_NL, cse_pkg::CFG_W'(brk));
		write_reg(cse_pkg::CFG_REPL_SQUOTE, cse_pkg::CFG_W'(repl));
		write_reg(cse_pkg::CFG_ALLOW_BREAK, cse_pkg::CFG_W'(allow));
		write_reg(cse_pkg::CFG_NUL_TERM, cse_pkg::CFG_W'(nul));
	endtask

	// Offers one byte and returns once its beat has been taken; valid stays up so
	// back-to-back bytes flow without a bubble unless random gaps are on.
	task automatic send_byte(input logic [7:0] value, input logic last);
		@(negedge clk);
		if (gaps_on && $urandom_range(0, 4) == 0) begin
			byte_ch.valid <= 1'b0;
			repeat ($urandom_range(1, 8)) @(negedge clk);
		end
		byte_ch.valid          <= 1'b1;
		byte_ch.in_byte        <= value;
		byte_ch.last_of_string <= last;
		do @(posedge clk); while (!byte_ch.ready);
	endtask

	// Waits until every expected character has arrived, then lets the block go quiet.
	task automatic settle();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (pending_chars != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);
	endtask

	// Text-like bytes: hex digits and question marks are frequent so that digits
	// often follow hex escapes and question marks come in pairs.
	function automatic logic [7:0] text_byte();
		case ($urandom_range(0, 9)) inside
			[0:2]: begin
				case ($urandom_range(0, 2))
					0: return cse_pkg::CH_ZERO + 8'($urandom_range(0, 9));
					1: return cse_pkg::CH_LA + 8'($urandom_range(0, 5));
					default: return cse_pkg::CH_UA + 8'($urandom_range(0, 5));
				endcase
			end
			[3:4]: return $urandom_range(0, 1) ? 8'($urandom_range(1, 31)) :
				8'($urandom_range(127, 255));
			5: return cse_pkg::CH_QMARK;
			6: return special_chars[$urandom_range(0, 7)];
			[7:8]: return 8'($urandom_range(32, 126));
			default: return 8'($urandom_range(0, 255));
		endcase
	endfunction

	initial begin
		logic [cse_pkg::CFG_W-1:0] limit;
		byte_ch.valid          = 1'b0;
		byte_ch.in_byte        = '0;
		byte_ch.last_of_string = 1'b0;
		cfg_we                 = 1'b0;
		cfg_index              = cse_pkg::CFG_LINE_LIMIT;
		cfg_data               = '0;
		gaps_on                = 1'b0;
		stalls_on              = 1'b0;
		hold_cycles            = 0;
		arst_n                 = 1'b0;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// Register defaults: NUL-terminated, no line limit.
		gaps_on   = 1'b1;
		stalls_on = 1'b1;
		foreach (nul_mode_cases[i]) begin
			send_byte(nul_mode_cases[i][7:0], nul_mode_cases[i][8]);
		end
		settle();

		// Counted strings with a short line and newline breaks.
		program_regs(10'd5, 1'b1, 1'b0, 1'b0, 1'b0);
		foreach (counted_cases[i]) begin
			send_byte(counted_cases[i][7:0], counted_cases[i][8]);
		end
		settle();

		// Grow a long line with no limit, then set a limit below the count reached:
		// the counter is already above it, so the next byte must break.
		program_regs(10'd0, 1'b0, 1'b1, 1'b1, 1'b1);
		for (int n = 0; n < LONG_LINE_ITEMS; n++) begin
			send_byte(8'($urandom_range(128, 255)), 1'($urandom_range(0, 1)));
		end
		settle();
		write_reg(cse_pkg::CFG_LINE_LIMIT, 10'd100);
		send_byte(8'h5A, 1'b0);
		settle();

		for (int p = 0; p < RANDOM_PHASES; p++) begin
			case (p)
				0: program_regs(10'd1, 1'b1, 1'b0, 1'b1, 1'b0);
				1: program_regs(10'd1023, 1'b0, 1'b1, 1'b0, 1'b1);
				RANDOM_PHASES - 1: program_regs(10'd16, 1'b1, 1'b1, 1'b1, 1'b1);
				default: begin
					limit = ($urandom_range(0, 3) == 0) ? 10'd0 : 10'($urandom_range(2, 60));
					program_regs(limit, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
						1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
				end
			endcase
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				if (n % 15 == 0) begin
					gaps_on   = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 2) != 0);
					stalls_on = (p != RANDOM_PHASES - 1) && ($urandom_range(0, 2) != 0);
				end
				// Long receiver hold-off while bytes keep coming, to fill the run queue.
				if (p == 1 && n == 6) begin
					hold_cycles = HOLD_OFF;
				end
				send_byte(text_byte(), $urandom_range(0, 7) == 0);
			end
			settle();
		end

		if (mismatches == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end

endmodule

// File: filelist.f
hdl/cse_pkg.sv
hdl/cse_if.sv
hdl/cse_front.sv
hdl/cse_queue.sv
hdl/cse_back.sv
hdl/c_string_escape_encoder_top.sv
sim/escape_checker.sv
sim/testbench.sv
